// ===== hdl/pclp_pkg.sv =====
// ----------------------------------------------------------------------------
// pclp_pkg
// Shared widths, constants and controller/datapath interface types for the
// per-core load percentage block.
// ----------------------------------------------------------------------------
`default_nettype none

package pclp_pkg;

  // Field widths
  localparam int CORE_W   = 4;
  localparam int CTR_W    = 40;
  localparam int NUM_CTR  = 10;
  localparam int ST_W     = 44;             // running total and busy stores
  localparam int DLT_W    = ST_W + 1;       // signed deltas
  localparam int PCT_W    = 7;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_RAW = CORE_W + NUM_CTR * CTR_W;
  localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
  localparam int M_DATA_W   = ((PCT_W + 7) / 8) * 8;

  // Position of the idle counter among the ten counters
  localparam int IDLE_SEL = 3;

  // Serial divider: dividend is |busy delta| * 100
  localparam int DIV_N_W   = DLT_W + PCT_W;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SEL_W     = $clog2(NUM_CTR);

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;   // take input transfer, read stores
    logic             add_en;    // accumulate one counter
    logic [SEL_W-1:0] add_sel;   // which counter to accumulate
    logic             busy_en;   // busy, total compare, increment
    logic             delta_en;  // signed deltas
    logic             scale_en;  // magnitudes, times 100, divider setup
    logic             div_en;    // one restoring divide step
    logic             out_load;  // load result, update stores
  } pclp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic core_ok;               // captured core index is in range
  } pclp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/pclp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pclp_ctrl
// Sequencer for one sample: accumulate, busy, delta, scale, serial divide, and
// hand off to the output register; an out-of-range core skips to the hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pclp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pclp_pkg::pclp_cmd_t      cmd_o,
  input  wire pclp_pkg::pclp_sts_t sts_i
);
  import pclp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_BUSY  = 7'b0000100,
    ST_DELTA = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    cmd_o.add_sel = cnt_q[SEL_W-1:0];
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.add_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_CTR - 1)) begin
          state_d = sts_i.core_ok ? ST_BUSY : ST_FIN;
        end
      end
      ST_BUSY: begin
        cmd_o.busy_en = 1'b1;
        state_d = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.delta_en = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/pclp_dpath.sv =====
// ----------------------------------------------------------------------------
// pclp_dpath
// Datapath: input capture, per-core total/busy stores, tick accumulator,
// signed deltas, times-100 scaling, radix-2 restoring divider and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pclp_dpath #(
  parameter int NUM_CORES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pclp_pkg::S_DATA_W-1:0] in_data_i,
  input  wire pclp_pkg::pclp_cmd_t           cmd_i,
  output pclp_pkg::pclp_sts_t                sts_o,
  output logic [pclp_pkg::PCT_W-1:0]         pct_o
);
  import pclp_pkg::*;

  localparam int AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  // Captured sample
  logic [CORE_W-1:0] core_q;
  logic [CTR_W-1:0]  ctr_q [NUM_CTR];

  // Store read data
  logic [ST_W-1:0]   rd_tot_q, rd_busy_q;
  logic              rd_vld_q;

  // Stores and their valid bits
  logic [ST_W-1:0]      tot_mem  [NUM_CORES];
  logic [ST_W-1:0]      busy_mem [NUM_CORES];
  logic [NUM_CORES-1:0] vld_q;

  // Arithmetic registers
  logic [ST_W-1:0]    acc_q, busy_q, sum_inc_q, new_busy_q;
  logic               eq_q;
  logic [DLT_W-1:0]   dbusy_q, dtotal_q;
  logic               neg_q;
  logic [DIV_N_W-1:0] div_n_q;
  logic [DLT_W-1:0]   div_d_q, rem_q;
  logic [PCT_W-1:0]   quo_q, pct_q;
  logic               ovf_q;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic               core_ok, wr_en;
  logic [ST_W-1:0]    last_tot, last_busy;
  logic [DLT_W-1:0]   mag_b, mag_t, trial;
  logic [DIV_N_W-1:0] mag_bx;
  logic               ge;

  assign rd_addr = AW'(in_data_i[CORE_W-1:0]);
  assign wr_addr = AW'(core_q);
  assign core_ok = 32'(core_q) < NUM_CORES;
  assign wr_en   = cmd_i.out_load && core_ok;
  assign sts_o.core_ok = core_ok;

  // Capture the input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      core_q <= in_data_i[CORE_W-1:0];
      for (int i = 0; i < NUM_CTR; i++) begin
        ctr_q[i] <= in_data_i[CORE_W + i*CTR_W +: CTR_W];
      end
    end
  end

  // Store read, registered, at capture time
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_tot_q  <= tot_mem[rd_addr];
      rd_busy_q <= busy_mem[rd_addr];
    end
  end

  // Store write at the end of a sample
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tot_mem[wr_addr]  <= sum_inc_q;
      busy_mem[wr_addr] <= new_busy_q;
    end
  end

  // Valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign last_tot  = rd_vld_q ? rd_tot_q  : '0;
  assign last_busy = rd_vld_q ? rd_busy_q : '0;

  // Accumulate one counter per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (cmd_i.add_en) begin
      acc_q <= acc_q + ST_W'(ctr_q[cmd_i.add_sel]);
    end
  end

  // Busy, and bump the total when it matches the stored one
  always_ff @(posedge clk_i) begin
    if (cmd_i.busy_en) begin
      busy_q    <= acc_q - ST_W'(ctr_q[IDLE_SEL]);
      eq_q      <= (acc_q == last_tot);
      sum_inc_q <= (acc_q == last_tot) ? acc_q + 1'b1 : acc_q;
    end
  end

  // Signed deltas and the busy value to store
  always_ff @(posedge clk_i) begin
    if (cmd_i.delta_en) begin
      dbusy_q    <= {1'b0, busy_q} - {1'b0, last_busy};
      dtotal_q   <= {1'b0, sum_inc_q} - {1'b0, last_tot};
      new_busy_q <= busy_q + ST_W'(eq_q);
    end
  end

  // Magnitudes and scale by 100 = 64 + 32 + 4
  assign mag_b  = dbusy_q[DLT_W-1]  ? (~dbusy_q + 1'b1)  : dbusy_q;
  assign mag_t  = dtotal_q[DLT_W-1] ? (~dtotal_q + 1'b1) : dtotal_q;
  assign mag_bx = DIV_N_W'(mag_b);

  // Divide step: shift in one dividend bit, subtract when it fits
  assign trial = {rem_q[DLT_W-2:0], div_n_q[DIV_N_W-1]};
  assign ge    = (trial >= div_d_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      neg_q   <= dbusy_q[DLT_W-1] ^ dtotal_q[DLT_W-1];
      div_n_q <= (mag_bx << 6) + (mag_bx << 5) + (mag_bx << 2);
      div_d_q <= mag_t;
      rem_q   <= '0;
      quo_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.div_en) begin
      div_n_q <= div_n_q << 1;
      rem_q   <= ge ? (trial - div_d_q) : trial;
      quo_q   <= {quo_q[PCT_W-2:0], ge};
      ovf_q   <= ovf_q | quo_q[PCT_W-1];
    end
  end

  // Clamp to 0..100 and hold the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (!core_ok || neg_q) begin
        pct_q <= '0;
      end else if (ovf_q || (quo_q > PCT_MAX)) begin
        pct_q <= PCT_MAX;
      end else begin
        pct_q <= quo_q;
      end
    end
  end

  assign pct_o = pct_q;

endmodule

`default_nettype wire

// ===== hdl/per_core_load_percent.sv =====
// Sequence: an input transfer for an in-range core passes the 10-step tick
//   accumulator, the busy, delta and scale steps and the 52-step radix-2 divider
//   before m_axis_tvalid; a core_index at or above NUM_CORES goes from the
//   accumulator to the output (result 0, stores untouched). One sample in flight.
// Reset: asynchronous, clears the controller and the per-core valid bits, so
//   every core's stored total and busy values read as zero after reset.
// ----------------------------------------------------------------------------
// per_core_load_percent
// Busy share of one core since its previous sample, in percent, from its ten
// cumulative tick counters.
// ----------------------------------------------------------------------------
`default_nettype none

module per_core_load_percent #(
  parameter int NUM_CORES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // core_index[3:0], user, nice, system, idle, iowait, hard_irq, soft_irq,
  // steal, guest, guest_nice (40 bits each), zero pad to 408 bits
  input  wire logic [pclp_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // load_percent[6:0], zero pad bit 7
  output logic [pclp_pkg::M_DATA_W-1:0]      m_axis_tdata
);
  import pclp_pkg::*;

  pclp_cmd_t        cmd;
  pclp_sts_t        sts;
  logic [PCT_W-1:0] pct;

  pclp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pclp_dpath #(
    .NUM_CORES (NUM_CORES)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .pct_o     (pct)
  );

  assign m_axis_tdata = M_DATA_W'(pct);

endmodule

`default_nettype wire
